/* design/ssd_pkg.sv */
// Shared types, constants and the segment lookup for the serial display sequencer.
// Used by ssd_front, ssd_back and the top level; no dependencies.
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int DISPLAY_POSITIONS_DEF = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SHOW   = 2'd1,
    CMD_BRIGHT = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SEC_START,
    SEC_DATA,
    SEC_STOP
  } sec_t;

  localparam logic [7:0] FRAME_DATA_CMD = 8'h40;
  localparam logic [7:0] FRAME_ADDR_CMD = 8'hC0;
  localparam logic [7:0] FRAME_BRIGHT   = 8'h88;
  localparam logic [7:0] SEG_BLANK      = 8'h00;

  localparam logic [4:0] BYTE_LAST_PH = 5'd17;
  localparam logic [4:0] ACK_FIRST_PH = 5'd16;
  localparam logic [4:0] STOP_LAST_PH = 5'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] digit0;
    logic [3:0] digit1;
    logic [3:0] digit2;
    logic [3:0] digit3;
    logic [2:0] digit_count;
    logic [3:0] level;
  } in_item_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic dio_drive;
    logic busy_res;
    logic rejected;
  } out_item_t;

  // Lines of one phase: clock, data, data driven.
  typedef struct packed {
    logic clk;
    logic dio;
    logic drive;
  } lines_t;

  localparam lines_t LINES_IDLE = '{clk: 1'b1, dio: 1'b1, drive: 1'b1};

  function automatic logic [7:0] seg_of(input logic [3:0] dg);
    logic [7:0] seg;
    case (dg)
      4'd0: seg = 8'h3F;
      4'd1: seg = 8'h06;
      4'd2: seg = 8'h5B;
      4'd3: seg = 8'h4F;
      4'd4: seg = 8'h66;
      4'd5: seg = 8'h6D;
      4'd6: seg = 8'h7D;
      4'd7: seg = 8'h07;
      4'd8: seg = 8'h7F;
      4'd9: seg = 8'h6F;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

/* design/seven_segment_serial_display_sequencer.sv */
// Two-wire seven-segment display sequencer. Every word pushed in yields exactly one
// result word: a tick plays one line phase (clock, data, data driven) of the loaded
// transfer, or idle lines when none plays; show-digits, set-brightness and clear load
// a new transfer when idle or are rejected while one is playing. Words are taken at
// one per clock sustained while results are popped; the back sequencer retires one
// word per cycle while its queue holds a word and the result queue has room. Each
// word passes an input register, a two-word queue and a two-word result queue on its
// way to the result ports. Depends on ssd_pkg, ssd_fifo, ssd_front and ssd_back.
`timescale 1ns / 1ps

module seven_segment_serial_display_sequencer #(
  parameter int DISPLAY_POSITIONS = ssd_pkg::DISPLAY_POSITIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ssd_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output ssd_pkg::out_item_t result
);

  localparam int QW = 10 + 8 * DISPLAY_POSITIONS;
  localparam int OW = $bits(ssd_pkg::out_item_t);

  logic               fq_push;
  logic [QW-1:0]      fq_wdata;
  logic               fq_full;
  logic               fq_pop;
  logic [QW-1:0]      fq_rdata;
  logic               fq_empty;
  logic               rq_push;
  logic               rq_full;
  ssd_pkg::out_item_t rq_wdata;
  logic [OW-1:0]      rq_rdata;

  ssd_front #(
    .DISPLAY_POSITIONS(DISPLAY_POSITIONS),
    .QW(QW)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_push (fq_push),
    .q_data (fq_wdata),
    .q_full (fq_full)
  );

  ssd_fifo #(
    .WIDTH(QW),
    .DEPTH(ssd_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  ssd_back #(
    .DISPLAY_POSITIONS(DISPLAY_POSITIONS),
    .QW(QW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (fq_empty),
    .q_data   (fq_rdata),
    .q_pop    (fq_pop),
    .out_full (rq_full),
    .out_push (rq_push),
    .out_item (rq_wdata)
  );

  ssd_fifo #(
    .WIDTH(OW),
    .DEPTH(ssd_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_rdata),
    .empty (empty)
  );

  assign result = ssd_pkg::out_item_t'(rq_rdata);

endmodule

/* design/ssd_fifo.sv */
// Small register queue used between the front and back parts and on the result side.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module ssd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/ssd_front.sv */
// Front part: accepts input words, builds the frame header and segment bytes.
// Depends on ssd_pkg for the input type, command codes and segment lookup.
`timescale 1ns / 1ps

module ssd_front #(
  parameter int DISPLAY_POSITIONS = ssd_pkg::DISPLAY_POSITIONS_DEF,
  parameter int QW = 10 + 8 * DISPLAY_POSITIONS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ssd_pkg::in_item_t item,
  output logic              full,
  output logic              q_push,
  output logic [QW-1:0]     q_data,
  input  logic              q_full
);

  localparam int P = DISPLAY_POSITIONS;
  localparam logic [2:0] MAX_CNT = (P < 4) ? 3'(P) : 3'd4;

  logic          valid;
  logic [QW-1:0] data;
  logic [QW-1:0] data_next;
  logic          take;

  logic [3:0]       dg [4];
  logic [7:0]       seg4 [4];
  logic [8*P-1:0]   segs_flat;
  logic [2:0]       cnt;
  logic             lead;
  logic [2:0]       lv_sat;
  logic [7:0]       byte0;

  assign full   = valid && q_full;
  assign take   = push && !full;
  assign q_push = valid;
  assign q_data = data;

  always_comb begin
    dg[0] = item.digit0;
    dg[1] = item.digit1;
    dg[2] = item.digit2;
    dg[3] = item.digit3;

    cnt = '0;
    if (item.command == ssd_pkg::CMD_SHOW) begin
      cnt = (item.digit_count > MAX_CNT) ? MAX_CNT : item.digit_count;
    end

    // Blank leading zeros, but keep the last shown digit.
    lead = 1'b1;
    for (int i = 0; i < 4; i++) begin
      seg4[i] = ssd_pkg::SEG_BLANK;
      if (3'(i) < cnt) begin
        if (dg[i] != 4'd0 || !lead || 3'(i) == cnt - 3'd1) begin
          lead    = 1'b0;
          seg4[i] = ssd_pkg::seg_of(dg[i]);
        end
      end
    end

    for (int i = 0; i < P; i++) begin
      segs_flat[8*i +: 8] = (i < 4) ? seg4[2'(i)] : ssd_pkg::SEG_BLANK;
    end

    lv_sat = (item.level > 4'd7) ? 3'd7 : item.level[2:0];
    byte0  = (item.command == ssd_pkg::CMD_BRIGHT) ?
             (ssd_pkg::FRAME_BRIGHT | {5'b0, lv_sat}) : ssd_pkg::FRAME_DATA_CMD;

    data_next = {item.command, byte0, segs_flat};
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data <= data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (!q_full) begin
      valid <= 1'b0;
    end
  end

endmodule

/* design/ssd_back.sv */
// Back part: holds the frame bytes and steps the two-wire line sequence.
// Depends on ssd_pkg for command codes, section states and result type.
`timescale 1ns / 1ps

module ssd_back #(
  parameter int DISPLAY_POSITIONS = ssd_pkg::DISPLAY_POSITIONS_DEF,
  parameter int QW = 10 + 8 * DISPLAY_POSITIONS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  logic [QW-1:0]      q_data,
  output logic               q_pop,
  input  logic               out_full,
  output logic               out_push,
  output ssd_pkg::out_item_t out_item
);

  localparam int P = DISPLAY_POSITIONS;
  localparam int FRAME_LEN = P + 2;
  localparam int IW = $clog2(FRAME_LEN);
  localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_LEN - 1);

  logic [7:0]       frame [FRAME_LEN];
  logic [1:0]       cmd;
  logic [7:0]       byte0;
  logic [8*P-1:0]   segs_flat;
  logic             go;
  logic             accept_cmd;

  ssd_pkg::sec_t    sec, sec_next;
  logic [4:0]       ph, ph_next;
  logic [IW-1:0]    idx, idx_next;
  logic             grp, grp_next;
  logic             busy, busy_next;
  logic             bright, bright_next;
  ssd_pkg::lines_t  last, last_next;
  ssd_pkg::lines_t  cur;

  assign cmd       = q_data[QW-1 -: 2];
  assign byte0     = q_data[QW-3 -: 8];
  assign segs_flat = q_data[8*P-1:0];
  assign go        = !q_empty && !out_full;
  assign q_pop     = go;
  assign out_push  = go;
  assign accept_cmd = go && !busy && (cmd != ssd_pkg::CMD_TICK);

  // Line levels of the phase about to be played.
  always_comb begin
    cur = ssd_pkg::LINES_IDLE;
    case (sec)
      ssd_pkg::SEC_START: begin
        cur.dio = (ph == 5'd0);
      end
      ssd_pkg::SEC_DATA: begin
        cur.clk = ph[0];
        if (ph < ssd_pkg::ACK_FIRST_PH) begin
          cur.dio = frame[idx][ph[3:1]];
        end else begin
          cur.dio   = 1'b0;
          cur.drive = 1'b0;
        end
      end
      ssd_pkg::SEC_STOP: begin
        cur.clk = (ph != 5'd0);
        cur.dio = (ph == ssd_pkg::STOP_LAST_PH);
      end
      default: cur = ssd_pkg::LINES_IDLE;
    endcase
  end

  always_comb begin
    sec_next    = sec;
    ph_next     = ph;
    idx_next    = idx;
    grp_next    = grp;
    busy_next   = busy;
    bright_next = bright;
    last_next   = last;

    out_item.clk_level = 1'b1;
    out_item.dio_level = 1'b1;
    out_item.dio_drive = 1'b1;
    out_item.busy_res  = 1'b0;
    out_item.rejected  = 1'b0;

    if (cmd == ssd_pkg::CMD_TICK) begin
      if (busy) begin
        out_item.clk_level = cur.clk;
        out_item.dio_level = cur.dio;
        out_item.dio_drive = cur.drive;
        out_item.busy_res  = 1'b1;
        if (go) begin
          last_next = cur;
          ph_next   = ph + 5'd1;
          case (sec)
            ssd_pkg::SEC_START: begin
              if (ph != 5'd0) begin
                sec_next = ssd_pkg::SEC_DATA;
                ph_next  = '0;
              end
            end
            ssd_pkg::SEC_DATA: begin
              if (ph == ssd_pkg::BYTE_LAST_PH) begin
                ph_next = '0;
                // Group one ends after byte zero, group two after the last byte.
                if (!grp || idx == LAST_IDX) begin
                  sec_next = ssd_pkg::SEC_STOP;
                end else begin
                  idx_next = idx + 1'b1;
                end
              end
            end
            ssd_pkg::SEC_STOP: begin
              if (ph == ssd_pkg::STOP_LAST_PH) begin
                ph_next  = '0;
                sec_next = ssd_pkg::SEC_START;
                if (!grp && !bright) begin
                  grp_next = 1'b1;
                  idx_next = idx + 1'b1;
                end else begin
                  busy_next = 1'b0;
                end
              end
            end
            default: sec_next = ssd_pkg::SEC_START;
          endcase
        end
      end
    end else if (busy) begin
      // Hold the sequence and repeat the last played lines.
      out_item.clk_level = last.clk;
      out_item.dio_level = last.dio;
      out_item.dio_drive = last.drive;
      out_item.busy_res  = 1'b1;
      out_item.rejected  = 1'b1;
    end else begin
      out_item.busy_res = 1'b1;
      if (go) begin
        busy_next   = 1'b1;
        bright_next = (cmd == ssd_pkg::CMD_BRIGHT);
        sec_next    = ssd_pkg::SEC_START;
        ph_next     = '0;
        idx_next    = '0;
        grp_next    = 1'b0;
        last_next   = ssd_pkg::LINES_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_cmd) begin
      frame[0] <= byte0;
      frame[1] <= ssd_pkg::FRAME_ADDR_CMD;
      for (int i = 0; i < P; i++) begin
        frame[i + 2] <= segs_flat[8*i +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec    <= ssd_pkg::SEC_START;
      ph     <= '0;
      idx    <= '0;
      grp    <= 1'b0;
      busy   <= 1'b0;
      bright <= 1'b0;
      last   <= ssd_pkg::LINES_IDLE;
    end else begin
      sec    <= sec_next;
      ph     <= ph_next;
      idx    <= idx_next;
      grp    <= grp_next;
      busy   <= busy_next;
      bright <= bright_next;
      last   <= last_next;
    end
  end

endmodule
